FILE: sv/tcc_pkg.sv
// types, constants and codes shared by the text console cursor engine
`default_nettype none

package tcc_pkg;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_CELLS = 2000;
  localparam int TAB_CELLS    = 4;
  localparam int STACK_DEPTH  = 256;
  localparam int VIDEO_CELLS  = 16384;

  localparam int CELL_W    = 14;
  localparam int SIZE_W    = 15;
  localparam int LIM_W     = 16;
  localparam int CNT_W     = 7;
  localparam int CHAR_W    = 8;
  localparam int KIND_W    = 2;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 1;

  localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
  localparam int SADDR_W = $clog2(STACK_DEPTH);

  // exact divide by the line width through a reciprocal multiply
  localparam int DIV_IN_W  = 15;
  localparam int DIV_SHIFT = DIV_IN_W + $clog2(SCREEN_COLS);
  localparam int RECIP_W   = DIV_IN_W + 1;
  localparam int DIV_RECIP = ((1 << DIV_SHIFT) + SCREEN_COLS - 1) / SCREEN_COLS;
  localparam int PROD_W    = DIV_IN_W + RECIP_W;
  localparam int QUOT_W    = PROD_W - DIV_SHIFT;

  localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DOWN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_HOME = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CELL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RANGE = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  localparam logic [CHAR_W-1:0] COLOR_DEFAULT = 8'h07;
  localparam logic [CHAR_W-1:0] COLOR_RED     = 8'h04;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 1'd1;

  localparam logic [CNT_W-1:0]  CNT_MAX    = 7'd127;
  localparam logic [CELL_W-1:0] SEARCH_MAX = 14'h3FFF;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic              esc_mode;
    logic [CELL_W-1:0] esc_begin;
  } tcc_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] write_kind;
    logic [CELL_W-1:0] write_addr;
    logic [CNT_W-1:0]  write_count;
    logic [CHAR_W-1:0] write_char;
    logic [CHAR_W-1:0] write_color;
    logic [CELL_W-1:0] cursor_pos;
    logic [CELL_W-1:0] display_start;
    logic [CELL_W-1:0] esc_count;
  } tcc_out_t;

endpackage

`default_nettype wire

FILE: sv/text_console_cursor_engine.sv
// top level of the text console cursor engine
`default_nettype none

// Takes a new item only after the last one has updated the cursor and
// while fewer than two results are pending. The pace is set by the cursor
// update loop: a newline needs the current line of the cursor, found by a
// reciprocal multiply and a line start computation, before the next item
// can read the cursor. The position stack is a 256 x 14 synchronous memory
// read a stage ahead of the cursor update; after a put command the display
// start is moved by whole lines in one reciprocal divide in the two stages
// that follow. A two-entry output queue lets new items enter while results wait.
module text_console_cursor_engine (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  tcc_pkg::tcc_in_t              in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output tcc_pkg::tcc_out_t             out_data,
  input  wire                           cfg_wen,
  input  wire  [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [tcc_pkg::CFG_W-1:0]     cfg_data
);

  import tcc_pkg::*;

  // configuration
  logic [CELL_W-1:0] origin;
  logic [SIZE_W-1:0] rsize;
  logic [LIM_W-1:0]  limit;

  // architectural state
  logic [CELL_W-1:0]  cursor;
  logic [CELL_W-1:0]  start;
  logic [LEVEL_W-1:0] level;
  logic [CELL_W-1:0]  search;
  logic [CELL_W-1:0]  stack_mem [STACK_DEPTH];
  logic [CELL_W-1:0]  stk_rd;
  logic [LEVEL_W-1:0] level_m1;

  // input register
  logic    hold_vld;
  tcc_in_t hold_item;
  logic    issue;
  logic [1:0] pending;

  // stage b
  logic              b_vld;
  tcc_in_t           b_item;
  logic [PROD_W-1:0] b_prod;
  logic [CELL_W-1:0] nl_diff;
  logic [QUOT_W-1:0] b_q;
  logic [31:0]       b_off;

  // stage c
  logic              c_vld;
  tcc_in_t           c_item;
  logic [CELL_W-1:0] c_target;

  logic [CELL_W-1:0]  cur_n;
  logic [LEVEL_W-1:0] level_n;
  logic [CELL_W-1:0]  search_n;
  logic               push_en;
  logic [KIND_W-1:0]  kind_n;
  logic [CELL_W-1:0]  addr_n;
  logic [CNT_W-1:0]   cnt_n;
  logic [CHAR_W-1:0]  char_n;
  logic [CHAR_W-1:0]  color_n;
  logic [CELL_W-1:0]  base_n;
  logic               scroll_n;
  logic [DIV_IN_W-1:0] m_n;
  logic [CELL_W-1:0]  bs_n;
  logic [LIM_W-1:0]   cur16;
  logic [LIM_W-1:0]   cur_n16;
  logic [LIM_W-1:0]   scr_end;
  logic [LIM_W-1:0]   m1;
  logic [LIM_W-1:0]   m2;
  logic               bs_blocked;

  // stage d
  logic                d_vld;
  tcc_out_t            d_res;
  logic [CELL_W-1:0]   d_base;
  logic                d_scroll;
  logic [DIV_IN_W-1:0] d_m;

  // stage e
  logic              e_vld;
  tcc_out_t          e_res;
  logic [CELL_W-1:0] e_base;
  logic              e_scroll;
  logic [PROD_W-1:0] e_prod;
  logic [QUOT_W-1:0] e_q;
  logic [31:0]       e_off;
  logic [CELL_W-1:0] start_n;
  tcc_out_t          e_out;

  // output queue
  tcc_out_t   q_mem [2];
  logic       q_wr;
  logic       q_rd;
  logic [1:0] q_cnt;
  logic       out_xfer;

  assign limit    = {2'b00, origin} + {1'b0, rsize};
  assign level_m1 = level - LEVEL_W'(1);
  assign out_xfer = out_valid && out_ready;

  // issue gap keeps the cursor update ahead of the next item
  assign issue    = hold_vld && !b_vld && !c_vld && (pending < 2'd2);
  assign in_ready = !hold_vld || issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      rsize  <= SIZE_W'(VIDEO_CELLS);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_ORIGIN: origin <= cfg_data[CELL_W-1:0];
        CFG_SIZE:   rsize  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_vld <= 1'b1;
    end else if (issue) begin
      hold_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_data;
    end
  end

  // items issued whose results have not been transferred out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({issue, out_xfer})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
    end
  end

  // stage a: line of the cursor through the reciprocal multiplier
  assign nl_diff = cursor - origin;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    b_item <= hold_item;
    b_prod <= PROD_W'(nl_diff) * PROD_W'(DIV_RECIP);
  end

  // stage b: start of the next line, stack read
  assign b_q   = b_prod[PROD_W-1:DIV_SHIFT];
  assign b_off = (32'(b_q) + 32'd1) * 32'(SCREEN_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_item   <= b_item;
    c_target <= origin + b_off[CELL_W-1:0];
    stk_rd   <= stack_mem[level_m1[SADDR_W-1:0]];
  end

  // stage c: cursor, stack and search count update
  assign cur16      = {2'b00, cursor};
  assign bs_n       = cursor - stk_rd;
  assign bs_blocked = (stk_rd < c_item.esc_begin) && (c_item.esc_begin > CELL_W'(1));

  always_comb begin
    cur_n    = cursor;
    level_n  = level;
    search_n = search;
    push_en  = 1'b0;
    kind_n   = KIND_NONE;
    addr_n   = '0;
    cnt_n    = '0;
    char_n   = '0;
    color_n  = '0;
    base_n   = start;
    case (c_item.command)
      CMD_PUT: begin
        case (c_item.char_code)
          CH_NEWLINE: begin
            if (cur16 + LIM_W'(SCREEN_COLS) < limit) begin
              push_en = 1'b1;
              cur_n   = (cursor >= origin) ? c_target : origin;
            end
          end
          CH_BACKSPACE: begin
            if (cursor > origin && level != '0) begin
              level_n = level_m1;
              if (!bs_blocked) begin
                if (stk_rd < cursor) begin
                  kind_n  = KIND_RANGE;
                  addr_n  = stk_rd;
                  cnt_n   = (bs_n > CELL_W'(CNT_MAX)) ? CNT_MAX : bs_n[CNT_W-1:0];
                  char_n  = CH_BLANK;
                  color_n = COLOR_DEFAULT;
                  if (c_item.esc_mode) begin
                    search_n = (search > bs_n) ? search - bs_n : '0;
                  end
                end
                cur_n = stk_rd;
              end
            end
          end
          CH_TAB: begin
            if (cur16 + LIM_W'(TAB_CELLS) < limit) begin
              kind_n  = KIND_RANGE;
              addr_n  = cursor;
              cnt_n   = CNT_W'(TAB_CELLS);
              char_n  = CH_BLANK;
              color_n = COLOR_DEFAULT;
              push_en = 1'b1;
              cur_n   = cursor + CELL_W'(TAB_CELLS);
            end
          end
          default: begin
            if (cur16 + LIM_W'(1) < limit) begin
              push_en = 1'b1;
              kind_n  = KIND_CELL;
              addr_n  = cursor;
              cnt_n   = CNT_W'(1);
              char_n  = c_item.char_code;
              if (c_item.esc_mode) begin
                color_n = COLOR_RED;
                if (search < SEARCH_MAX) begin
                  search_n = search + CELL_W'(1);
                end
              end else begin
                color_n = COLOR_DEFAULT;
              end
              cur_n = cursor + CELL_W'(1);
            end
          end
        endcase
        if (push_en && level < LEVEL_W'(STACK_DEPTH)) begin
          level_n = level + LEVEL_W'(1);
        end
      end
      CMD_UP: begin
        if (start > origin) begin
          base_n = start - CELL_W'(SCREEN_COLS);
        end
      end
      CMD_DOWN: begin
        if ({2'b00, start} + LIM_W'(SCREEN_CELLS) < limit) begin
          base_n = start + CELL_W'(SCREEN_COLS);
        end
      end
      CMD_HOME: begin
        cur_n    = origin;
        base_n   = origin;
        level_n  = '0;
        search_n = '0;
      end
      default: ;
    endcase
  end

  // lines to scroll: smaller of the cursor overshoot and the room left
  assign cur_n16  = {2'b00, cur_n};
  assign scr_end  = {2'b00, start} + LIM_W'(SCREEN_CELLS);
  assign m1       = cur_n16 - scr_end;
  assign m2       = limit - scr_end - LIM_W'(1);
  assign scroll_n = (c_item.command == CMD_PUT) && (cur_n16 >= scr_end) && (scr_end < limit);
  assign m_n      = (m1 < m2) ? m1[DIV_IN_W-1:0] : m2[DIV_IN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      level  <= '0;
      search <= '0;
      d_vld  <= 1'b0;
    end else begin
      d_vld <= c_vld;
      if (c_vld) begin
        cursor <= cur_n;
        level  <= level_n;
        search <= search_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_vld && c_item.command == CMD_PUT && push_en && level < LEVEL_W'(STACK_DEPTH)) begin
      stack_mem[level[SADDR_W-1:0]] <= cursor;
    end
  end

  always_ff @(posedge clk) begin
    d_res.write_kind    <= kind_n;
    d_res.write_addr    <= addr_n;
    d_res.write_count   <= cnt_n;
    d_res.write_char    <= char_n;
    d_res.write_color   <= color_n;
    d_res.cursor_pos    <= cur_n;
    d_res.display_start <= base_n;
    d_res.esc_count     <= search_n;
    d_base              <= base_n;
    d_scroll            <= scroll_n;
    d_m                 <= m_n;
  end

  // stage d: scroll divide
  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    e_res    <= d_res;
    e_base   <= d_base;
    e_scroll <= d_scroll;
    e_prod   <= PROD_W'(d_m) * PROD_W'(DIV_RECIP);
  end

  // stage e: new display start and result
  assign e_q     = e_prod[PROD_W-1:DIV_SHIFT];
  assign e_off   = (32'(e_q) + 32'd1) * 32'(SCREEN_COLS);
  assign start_n = e_scroll ? e_base + e_off[CELL_W-1:0] : e_base;

  always_comb begin
    e_out               = e_res;
    e_out.display_start = start_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
    end else if (e_vld) begin
      start <= start_n;
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (e_vld) begin
      q_mem[q_wr] <= e_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= 1'b0;
      q_rd  <= 1'b0;
      q_cnt <= '0;
    end else begin
      if (e_vld) begin
        q_wr <= !q_wr;
      end
      if (out_xfer) begin
        q_rd <= !q_rd;
      end
      case ({e_vld, out_xfer})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  assign out_valid = (q_cnt != '0);
  assign out_data  = q_mem[q_rd];

endmodule

`default_nettype wire
